// ===== design/dmla_pkg.sv =====
// Shared types, constants and lane helpers for the data memory lane access core.
package dmla_pkg;

    localparam int MEM_BYTES  = 4096;
    localparam int WORD_COUNT = (MEM_BYTES + 3) / 4;
    localparam int IDX_W      = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [2:0] SIZE_BYTE = 3'd1;
    localparam logic [2:0] SIZE_HALF = 3'd2;
    localparam logic [2:0] SIZE_WORD = 3'd4;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_RANGE    = 2'd1;
    localparam logic [1:0] STATUS_BAD_SIZE = 2'd2;

    typedef logic [IDX_W-1:0] idx_t;

    typedef struct packed {
        logic        cmd;
        logic [31:0] addr;
        logic [31:0] wdata;
        logic [2:0]  size_code;
    } req_t;

    typedef struct packed {
        logic [31:0] rdata;
        logic [1:0]  status;
    } rsp_t;

    // access held in the memory stage
    typedef struct packed {
        logic        cmd;
        logic [31:0] wdata;
        logic [2:0]  size_code;
        logic [1:0]  lane;
        logic        in_window;
    } stage_t;

    // outcome of the lane logic
    typedef struct packed {
        logic        we;
        logic [31:0] word;
        rsp_t        rsp;
    } lane_res_t;

    function automatic logic [31:0] sext8(input logic [31:0] v);
        return {{24{v[7]}}, v[7:0]};
    endfunction

    function automatic logic [31:0] sext16(input logic [31:0] v);
        return {{16{v[15]}}, v[15:0]};
    endfunction

endpackage

// ===== design/dmla_ram.sv =====
// Single-port-write, single-port-read synchronous word memory with a registered read output.
module dmla_ram
(
    input  logic               clk,
    input  logic               we,
    input  dmla_pkg::idx_t     waddr,
    input  logic [31:0]        wdata,
    input  logic               re,
    input  dmla_pkg::idx_t     raddr,
    output logic [31:0]        rdata
);
    import dmla_pkg::*;

    logic [31:0] mem [WORD_COUNT];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/dmla_lane.sv =====
// Byte and halfword lane merge for writes and lane extract with sign extension for reads.
module dmla_lane
(
    input  dmla_pkg::stage_t    stage,
    input  logic [31:0]         word,
    output dmla_pkg::lane_res_t res
);
    import dmla_pkg::*;

    logic [4:0]  sh;
    logic [31:0] shifted;
    logic [31:0] mask;
    logic [31:0] lane_data;
    logic        size_ok;

    assign sh      = {stage.lane, 3'b000};
    assign shifted = word >> sh;

    always_comb
    begin
        mask      = 32'hFFFF_FFFF;
        lane_data = stage.wdata;
        size_ok   = 1'b1;
        case (stage.size_code)
            SIZE_BYTE:
            begin
                mask      = 32'h0000_00FF << sh;
                lane_data = {24'd0, stage.wdata[7:0]} << sh;
            end
            SIZE_HALF:
            begin
                mask      = 32'h0000_FFFF << sh;
                lane_data = {16'd0, stage.wdata[15:0]} << sh;
            end
            SIZE_WORD:
            begin
                mask      = 32'hFFFF_FFFF;
                lane_data = stage.wdata;
            end
            default:
            begin
                size_ok = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        res.we         = 1'b0;
        res.word       = (word & ~mask) | lane_data;
        res.rsp.rdata  = 32'd0;
        res.rsp.status = STATUS_OK;
        if (!stage.in_window)
        begin
            res.rsp.status = STATUS_RANGE;
        end
        else if (stage.cmd == CMD_WRITE)
        begin
            if (size_ok)
            begin
                res.we = 1'b1;
            end
            else
            begin
                res.rsp.status = STATUS_BAD_SIZE;
            end
        end
        else
        begin
            case (stage.size_code)
                SIZE_BYTE: res.rsp.rdata = sext8(shifted);
                SIZE_HALF: res.rsp.rdata = sext16(shifted);
                default:   res.rsp.rdata = word;
            endcase
        end
    end

endmodule

// ===== design/data_memory_lane_access_core.sv =====
// Top level: windowed word memory with byte-lane load/store and registered response.
// Requests pass the memory stage; responses are registered when that stage advances.
// Throughput: one transaction per cycle unless the response stalls; a back-to-back access
// to the same word is served by forwarding the preceding write's word around the memory.
// Reset: clears pipeline valids, the response valid and window_base to 0;
// memory contents are undefined until written and are not cleared.
module data_memory_lane_access_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [31:0]      cfg_data,
    input  logic             req_valid,
    output logic             req_ready,
    input  dmla_pkg::req_t   req,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output dmla_pkg::rsp_t   rsp
);
    import dmla_pkg::*;

    logic [31:0] window_base_reg;
    logic        s1_valid_reg;
    stage_t      s1_reg;
    idx_t        s1_idx_reg;
    logic        fwd_valid_reg;
    logic [31:0] fwd_word_reg;
    logic        rsp_valid_reg;
    rsp_t        rsp_reg;

    logic [31:0] off;
    idx_t        req_idx;
    logic        accept;
    logic        advance;
    logic        mem_we;
    logic [31:0] mem_q;
    logic [31:0] cur_word;
    lane_res_t   res;
    stage_t      s1_next;

    assign cfg_ready = 1'b1;

    assign off     = req.addr - window_base_reg;
    assign req_idx = off[IDX_W+1:2];

    assign advance   = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !s1_valid_reg || advance;
    assign accept    = req_valid && req_ready;
    assign mem_we    = advance && res.we;

    always_comb
    begin
        s1_next.cmd       = req.cmd;
        s1_next.wdata     = req.wdata;
        s1_next.size_code = req.size_code;
        s1_next.lane      = off[1:0];
        s1_next.in_window = off < 32'(MEM_BYTES);
    end

    dmla_ram u_ram
    (
        .clk   (clk),
        .we    (mem_we),
        .waddr (s1_idx_reg),
        .wdata (res.word),
        .re    (accept),
        .raddr (req_idx),
        .rdata (mem_q)
    );

    assign cur_word = fwd_valid_reg ? fwd_word_reg : mem_q;

    dmla_lane u_lane
    (
        .stage (s1_reg),
        .word  (cur_word),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_base_reg <= 32'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            window_base_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg  <= 1'b1;
                fwd_valid_reg <= mem_we && (s1_idx_reg == req_idx);
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg       <= s1_next;
            s1_idx_reg   <= req_idx;
            fwd_word_reg <= res.word;
        end
        if (advance)
        begin
            rsp_reg <= res.rsp;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== verif/dmla_checker.sv =====
// Checker for the data memory lane access core: mirrors the memory, predicts and compares responses.
module dmla_checker
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_valid,
    input  logic           cfg_ready,
    input  logic [31:0]    cfg_data,
    input  logic           req_valid,
    input  logic           req_ready,
    input  dmla_pkg::req_t req,
    input  logic           rsp_valid,
    input  logic           rsp_ready,
    input  dmla_pkg::rsp_t rsp,
    output int             fail_count,
    output int             pending
);
    import dmla_pkg::*;

    logic [31:0] mem_mirror [WORD_COUNT];
    logic [31:0] window_base = '0;
    rsp_t        expected_rsp_q [$];
    int          n_fail = 0;

    // applies one access to the mirror and returns its response
    function automatic rsp_t service_access(input req_t r);
        rsp_t        o;
        logic [31:0] off;
        logic [31:0] word;
        logic [4:0]  sh;
        idx_t        wi;
        o = '0;
        off = r.addr - window_base;
        if (off >= MEM_BYTES)
        begin
            o.status = STATUS_RANGE;
            return o;
        end
        wi = off[IDX_W+1:2];
        sh = {off[1:0], 3'b000};
        word = mem_mirror[wi];
        if (r.cmd == CMD_WRITE)
        begin
            case (r.size_code)
                SIZE_BYTE: mem_mirror[wi] = (word & ~(32'hFF << sh)) | ((r.wdata & 32'hFF) << sh);
                SIZE_HALF: mem_mirror[wi] = (word & ~(32'hFFFF << sh))
                                            | ((r.wdata & 32'hFFFF) << sh);
                SIZE_WORD: mem_mirror[wi] = r.wdata;
                default:   o.status = STATUS_BAD_SIZE;
            endcase
        end
        else
        begin
            word = word >> sh;
            case (r.size_code)
                SIZE_BYTE: o.rdata = {{24{word[7]}}, word[7:0]};
                SIZE_HALF: o.rdata = {{16{word[15]}}, word[15:0]};
                default:   o.rdata = mem_mirror[wi];
            endcase
        end
        return o;
    endfunction

    always @(posedge clk)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            window_base = '0;
            expected_rsp_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                window_base = cfg_data;
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsp_q.size() == 0)
                begin
                    $display("%0t: unexpected response, expected none, actual rdata %h status %0d",
                             $time, rsp.rdata, rsp.status);
                    n_fail++;
                end
                else
                begin
                    want = expected_rsp_q.pop_front();
                    if (rsp.rdata !== want.rdata)
                    begin
                        $display("%0t: rdata mismatch, expected %h, actual %h",
                                 $time, want.rdata, rsp.rdata);
                        n_fail++;
                    end
                    if (rsp.status !== want.status)
                    begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, rsp.status);
                        n_fail++;
                    end
                end
            end
            if (req_valid && req_ready)
                expected_rsp_q.push_back(service_access(req));
        end
        fail_count <= n_fail;
        pending    <= expected_rsp_q.size();
    end

endmodule

// ===== verif/tb_data_memory_lane_access_core.sv =====
// Testbench top for the data memory lane access core: clock, reset, stimulus and verdict.
module tb_data_memory_lane_access_core;
    import dmla_pkg::*;

    localparam int         CYCLE_LIMIT     = 200000;
    localparam int         ITEMS_PER_PHASE = 100;
    localparam logic [2:0] SIZE_ZERO       = 3'd0;
    localparam logic [2:0] SIZE_ALL_ONES   = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;
    logic        req_valid;
    logic        req_ready;
    req_t        req;
    logic        rsp_valid;
    logic        rsp_ready;
    rsp_t        rsp;
    int          fail_count;
    int          pending;
    int          cycles = 0;
    bit          quiet = 1'b0;
    bit          word_init [WORD_COUNT];
    logic [31:0] cur_base = '0;

    data_memory_lane_access_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    dmla_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk)
        rsp_ready <= quiet || ($urandom_range(0, 99) >= 31);

    function automatic logic in_window(input logic [31:0] a, output idx_t wi);
        logic [31:0] off;
        off = a - cur_base;
        wi = off[IDX_W+1:2];
        return off < MEM_BYTES;
    endfunction

    task automatic send_access(input logic c, input logic [31:0] a, input logic [31:0] d,
                               input logic [2:0] s);
        req_t r;
        idx_t wi;
        r.cmd = c;
        r.addr = a;
        r.wdata = d;
        r.size_code = s;
        if (!quiet && $urandom_range(0, 99) < 31)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        if (in_window(a, wi) && c == CMD_WRITE && s == SIZE_WORD)
            word_init[wi] = 1'b1;
        req_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
    endtask

    task automatic wait_idle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic set_window(input logic [31:0] b);
        wait_idle();
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= b;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        cur_base = b;
    endtask

    initial
    begin
        logic [31:0] phase_base [7];
        logic [31:0] a;
        logic [31:0] d;
        logic [2:0]  s;
        logic        c;
        idx_t        wi;
        int unsigned sel;

        cfg_valid <= 1'b0;
        cfg_data <= '0;
        req_valid <= 1'b0;
        req <= '0;
        rsp_ready <= 1'b0;
        phase_base = '{32'hFFFF_F800, 32'h0000_1003, 32'hFFFF_FFFF, 32'h8000_0002,
                       $urandom, 32'h0000_0000, 32'h7FFF_FFFC};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: lanes, sign extension, odd sizes, window edges
        set_window(32'h0000_0000);
        send_access(CMD_WRITE, 32'h0, 32'h80FF_7F01, SIZE_WORD);
        send_access(CMD_READ, 32'h0, 32'h0, SIZE_WORD);
        send_access(CMD_READ, 32'h0, 32'h0, SIZE_BYTE);
        send_access(CMD_READ, 32'h1, 32'h0, SIZE_BYTE);
        send_access(CMD_READ, 32'h2, 32'h0, SIZE_BYTE);
        send_access(CMD_READ, 32'h3, 32'h0, SIZE_BYTE);
        send_access(CMD_READ, 32'h0, 32'h0, SIZE_HALF);
        send_access(CMD_READ, 32'h1, 32'h0, SIZE_HALF);
        send_access(CMD_READ, 32'h2, 32'h0, SIZE_HALF);
        send_access(CMD_READ, 32'h3, 32'h0, SIZE_HALF);
        send_access(CMD_WRITE, 32'h2, 32'hFFFF_FF5A, SIZE_BYTE);
        send_access(CMD_WRITE, 32'h3, 32'h0000_ABCD, SIZE_HALF);
        send_access(CMD_READ, 32'h0, 32'h0, SIZE_WORD);
        send_access(CMD_WRITE, 32'h4, 32'hFFFF_FFFF, SIZE_WORD);
        send_access(CMD_WRITE, 32'h5, 32'h0000_1234, SIZE_HALF);
        send_access(CMD_READ, 32'h5, 32'h0, SIZE_HALF);
        send_access(CMD_READ, 32'h4, 32'h0, SIZE_ZERO);
        send_access(CMD_READ, 32'h4, 32'h0, SIZE_ALL_ONES);
        send_access(CMD_WRITE, 32'h0, 32'h1111_1111, SIZE_ZERO);
        send_access(CMD_WRITE, 32'h1, 32'h2222_2222, SIZE_ALL_ONES);
        send_access(CMD_READ, MEM_BYTES, 32'h0, SIZE_BYTE);
        send_access(CMD_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, SIZE_WORD);
        send_access(CMD_WRITE, MEM_BYTES - 4, 32'h7FFF_8000, SIZE_WORD);
        send_access(CMD_READ, MEM_BYTES - 1, 32'h0, SIZE_BYTE);
        send_access(CMD_READ, MEM_BYTES - 2, 32'h0, SIZE_HALF);

        foreach (phase_base[p])
        begin
            set_window(phase_base[p]);
            quiet = (p == 2);
            repeat (ITEMS_PER_PHASE)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 8)
                    a = $urandom;
                else if (sel < 14)
                    a = cur_base + MEM_BYTES + $urandom_range(0, 64);
                else if (sel < 18)
                    a = cur_base - 32'd1 - $urandom_range(0, 64);
                else
                begin
                    if ($urandom_range(0, 3) == 0)
                        wi = idx_t'($urandom_range(0, WORD_COUNT - 1));
                    else
                        wi = idx_t'(($urandom_range(0, 1) == 1 ? WORD_COUNT - 8 : 0)
                                    + $urandom_range(0, 7));
                    a = cur_base + {wi, 2'b00} + $urandom_range(0, 3);
                end
                c = 1'($urandom_range(0, 1));
                sel = $urandom_range(0, 9);
                if (sel < 3)
                    s = SIZE_BYTE;
                else if (sel < 6)
                    s = SIZE_HALF;
                else if (sel < 8)
                    s = SIZE_WORD;
                else
                begin
                    do s = 3'($urandom_range(0, 7));
                    while (s == SIZE_BYTE || s == SIZE_HALF || s == SIZE_WORD);
                end
                sel = $urandom_range(0, 9);
                d = (sel == 0) ? 32'h0 : (sel == 1) ? 32'hFFFF_FFFF : $urandom;
                // a word must hold a full write before any other access touches it
                if (in_window(a, wi) && !word_init[wi])
                begin
                    c = CMD_WRITE;
                    s = SIZE_WORD;
                end
                send_access(c, a, d, s);
            end
            quiet = 1'b0;
        end

        wait_idle();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
